/* hw/rtl/fpo_pkg.sv */
package fpo_pkg;

   localparam int DIST_BITS = 38;
   localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_REQUEST = 2'd1,
      CMD_CLEAR   = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_READY = 2'd1,
      ST_DONE      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_POINT_COUNT = 2'd0,
      REG_DIMS_IN_USE = 2'd1,
      REG_START_INDEX = 2'd2
   } reg_index_type;

   // Control from the sequencer to the distance datapath.
   typedef struct packed {
      logic       coord_valid;  // a coordinate pair arrives this cycle
      logic       first_dim;    // first coordinate of a point
      logic       last_dim;     // last coordinate of a point
   } dp_ctrl_type;

endpackage

/* hw/rtl/fpo_dist.sv */
// Accumulates squared coordinate differences of one point against the current
// center, one coordinate per cycle, with saturation at the distance maximum.
module fpo_dist #(
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fpo_pkg::dp_ctrl_type          ctrl,
   input  logic signed [COORD_BITS-1:0]  coord_a,
   input  logic signed [COORD_BITS-1:0]  coord_b,
   output logic                          dist_valid,
   output logic [fpo_pkg::DIST_BITS-1:0] dist_out
);
   import fpo_pkg::*;

   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int MAG_LIM = 19;

   logic signed [DIFF_BITS-1:0] diff;
   logic [DIFF_BITS-1:0]        mag;
   logic                        big;
   logic [MAG_LIM-1:0]          mag_ff, mag_in;
   logic                        sat_ff, sat_in;
   logic                        v1_ff, first1_ff, last1_ff;
   logic [2*MAG_LIM-1:0]        sq;
   logic [DIST_BITS:0]          sum;
   logic [DIST_BITS-1:0]        acc_ff, acc_in;
   logic                        vout_ff;

   always_comb begin
      diff = DIFF_BITS'(coord_a) - DIFF_BITS'(coord_b);
      mag  = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
      if (DIFF_BITS > MAG_LIM) begin
         big = (mag > DIFF_BITS'(20'h7FFFF));
      end else begin
         big = 1'b0;
      end
      mag_in = MAG_LIM'(mag);
      sat_in = big;
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      sat_ff <= sat_in;
      first1_ff <= ctrl.first_dim;
      last1_ff  <= ctrl.last_dim;
      acc_ff <= acc_in;
   end

   always_comb begin
      sq  = mag_ff * mag_ff;
      sum = (first1_ff ? (DIST_BITS+1)'(0) : {1'b0, acc_ff}) + (DIST_BITS+1)'(sq);
      acc_in = acc_ff;
      if (v1_ff) begin
         if (sat_ff || (!first1_ff && acc_ff == DIST_MAX) || sum[DIST_BITS]) begin
            acc_in = DIST_MAX;
         end else begin
            acc_in = sum[DIST_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         vout_ff <= 1'b0;
      end else begin
         v1_ff   <= ctrl.coord_valid;
         vout_ff <= v1_ff && last1_ff;
      end
   end

   assign dist_valid = vout_ff;
   assign dist_out   = acc_ff;

endmodule

/* hw/rtl/farthest_point_order_top.sv */
// Farthest-first point ordering.
// Input stream (req_): tuser carries the command in bits 1:0 and tdata carries
// the signed Q8.8 coordinate in bits 15:0. Load beats store coordinates in
// point-major order, request beats ask for the next permutation index, clear
// beats restart loading and the traversal. Only a request returns a result.
// Result stream (rsp_): tdata carries point_index in bits 9:0, tuser carries
// the status in bits 1:0 and tlast marks the final index of the permutation.
// Configuration (csr_): index 0 point_count, 1 dims_in_use, 2 start_index;
// write only while the block is idle.
// A request that cannot emit an index presents its result on the cycle
// after it is accepted. A request that emits an index first reads the
// center's coordinates and then every point's coordinates from the point
// store, one per cycle through its single read port, before rsp_tvalid
// rises. No beat is accepted while a result is in flight.
// Reset clears control state and starts a clearing pass over all MAX_POINTS
// entries of the distance memory, during which no beat is accepted. A clear
// command runs the same pass. A waiting result blocks new input until taken;
// a stalled receiver simply holds rsp_tvalid high.
module farthest_point_order_top #(
   parameter int MAX_POINTS = 1024,
   parameter int MAX_DIMS   = 16,
   parameter int COORD_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // coord[15:0]
   input  logic [1:0]  req_tuser,   // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // point_index[9:0]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);
   import fpo_pkg::*;

   localparam int PB = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int DB = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int SD = MAX_POINTS * MAX_DIMS;
   localparam int SB = $clog2(SD + 1);
   localparam int AB = (SD > 1) ? $clog2(SD) : 1;
   localparam int CB = $clog2(MAX_POINTS + 1);

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_SCAN  = 6'b000100,
      S_DRAIN = 6'b001000,
      S_FIN   = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [10:0] pc_ff;
   logic [4:0]  dc_ff;
   logic [9:0]  si_ff;

   logic [PB:0] npts;
   logic [DB:0] dims;
   logic [SB-1:0] total;

   always_comb begin
      if (pc_ff == 11'd0) npts = (PB+1)'(1);
      else if ({21'd0, pc_ff} > 32'(MAX_POINTS)) npts = (PB+1)'(MAX_POINTS);
      else npts = (PB+1)'(pc_ff);
      if (dc_ff == 5'd0) dims = (DB+1)'(1);
      else if ({27'd0, dc_ff} > 32'(MAX_DIMS)) dims = (DB+1)'(MAX_DIMS);
      else dims = (DB+1)'(dc_ff);
   end

   assign total = SB'(npts) * SB'(dims);

   // Point store: one write port for loads, one read port for the scan.
   logic [COORD_BITS-1:0] pstore [SD];
   logic                  st_we;
   logic [AB-1:0]         st_wa, st_ra;
   logic [COORD_BITS-1:0] st_rd_ff;
   always_ff @(posedge clock) begin
      if (st_we) pstore[st_wa] <= COORD_BITS'(req_tdata);
      st_rd_ff <= pstore[st_ra];
   end

   // Center coordinates buffered during the scan of point zero are avoided by
   // a center register file filled in a preload pass.
   logic [COORD_BITS-1:0] ctr_ff [MAX_DIMS];

   // Nearest-distance memory.
   logic [DIST_BITS-1:0] nd [MAX_POINTS];
   logic                 nd_we;
   logic [PB-1:0]        nd_wa, nd_ra;
   logic [DIST_BITS-1:0] nd_wd, nd_rd_ff;
   always_ff @(posedge clock) begin
      if (nd_we) nd[nd_wa] <= nd_wd;
      nd_rd_ff <= nd[nd_ra];
   end

   logic [SB-1:0] load_ff, load_in;
   logic [CB-1:0] emit_ff, emit_in;
   logic [PB-1:0] choice_ff, choice_in;
   logic [PB-1:0] cur_ff, cur_in;
   logic [PB:0]   clr_ff, clr_in;
   // scan counters: phase 0 preloads center, phase 1 walks points
   logic          pre_ff, pre_in;
   logic [PB:0]   pt_ff, pt_in;
   logic [DB:0]   dm_ff, dm_in;
   logic [PB:0]   done_ff, done_in;
   logic [PB-1:0] best_ff, best_in;
   logic [DIST_BITS-1:0] bestd_ff, bestd_in;
   logic          rd_v_ff, rd_pre_ff, rd_first_ff, rd_last_ff;
   logic [DB-1:0] rd_dm_ff;
   logic [PB:0]   rd_pt_ff;
   logic [PB-1:0] pt1_ff, dpt_ff;
   logic          dist_valid;
   logic [DIST_BITS-1:0] pt_dist;
   logic          upd_v_ff;
   logic [DIST_BITS-1:0] upd_d_ff;
   logic [PB-1:0] upd_pt_ff;
   logic [9:0]    o_idx_ff, o_idx_in;
   logic [1:0]    o_st_ff, o_st_in;
   logic          o_last_ff, o_last_in;
   dp_ctrl_type   ctrl;

   cmd_type cmd;
   assign cmd = cmd_type'(req_tuser);
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   wire   acc = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= 11'd1;
         dc_ff <= 5'd1;
         si_ff <= 10'd0;
      end else if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_POINT_COUNT: pc_ff <= csr_data;
            REG_DIMS_IN_USE: dc_ff <= csr_data[4:0];
            REG_START_INDEX: si_ff <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      load_in = load_ff; emit_in = emit_ff; choice_in = choice_ff; cur_in = cur_ff;
      clr_in = clr_ff; pre_in = pre_ff; pt_in = pt_ff; dm_in = dm_ff;
      done_in = done_ff; best_in = best_ff; bestd_in = bestd_ff;
      o_idx_in = o_idx_ff; o_st_in = o_st_ff; o_last_in = o_last_ff;
      st_we = 1'b0;
      st_wa = AB'(load_ff);
      st_ra = '0;
      nd_we = 1'b0; nd_wa = '0; nd_wd = DIST_MAX;
      nd_ra = '0;
      unique case (state_ff)
         S_CLEAR: begin
            nd_we = 1'b1; nd_wa = clr_ff[PB-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (PB+1)'(MAX_POINTS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (acc) begin
               unique case (cmd)
                  CMD_LOAD: begin
                     if (load_ff < total && 32'(load_ff) < SD) begin
                        st_we = 1'b1; load_in = load_ff + 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     load_in = '0; emit_in = '0; choice_in = '0;
                     clr_in = '0; state_in = S_CLEAR;
                  end
                  CMD_REQUEST: begin
                     o_idx_in = '0; o_last_in = 1'b0;
                     if (load_ff < total) begin
                        o_st_in = ST_NOT_READY; state_in = S_OUT;
                     end else if (emit_ff >= CB'(npts)) begin
                        o_st_in = ST_DONE; state_in = S_OUT;
                     end else begin
                        o_st_in = ST_OK;
                        if (emit_ff == '0)
                           cur_in = ({22'd0, si_ff} < 32'(npts)) ? PB'(si_ff) : '0;
                        else
                           cur_in = ({1'b0, choice_ff} < npts) ? choice_ff : '0;
                        pre_in = 1'b1; pt_in = '0; dm_in = '0; done_in = '0;
                        state_in = S_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            st_ra = AB'(pre_ff ? {1'b0, cur_ff} : pt_ff) * AB'(dims) + AB'(dm_ff);
            if (dm_ff == dims - 1'b1) begin
               dm_in = '0;
               if (pre_ff) pre_in = 1'b0;
               else begin
                  pt_in = pt_ff + 1'b1;
                  if (pt_ff == npts - 1'b1) state_in = S_DRAIN;
               end
            end else dm_in = dm_ff + 1'b1;
         end
         default: ;
      endcase
      // distance memory read issued as the distance leaves the datapath
      nd_ra = dpt_ff;
      if (upd_v_ff) begin
         logic [DIST_BITS-1:0] nv;
         nv = (upd_d_ff < nd_rd_ff) ? upd_d_ff : nd_rd_ff;
         nd_we = 1'b1; nd_wa = upd_pt_ff; nd_wd = nv;
         if (done_ff == '0 || nv > bestd_ff) begin
            bestd_in = nv; best_in = upd_pt_ff;
         end
         done_in = done_ff + 1'b1;
      end
      if (state_ff == S_DRAIN && done_ff == npts) begin
         choice_in = best_ff; emit_in = emit_ff + 1'b1;
         o_idx_in = 10'(cur_ff);
         o_last_in = (emit_ff + 1'b1 == CB'(npts));
         state_in = S_OUT;
      end
      if (state_ff == S_OUT && rsp_tready) state_in = S_IDLE;
   end

   // Capture center coordinates during the preload pass.
   always_ff @(posedge clock) begin
      if (rd_v_ff && rd_pre_ff) ctr_ff[rd_dm_ff] <= st_rd_ff;
   end

   always_ff @(posedge clock) begin
      rd_v_ff     <= (state_ff == S_SCAN);
      rd_pre_ff   <= pre_ff;
      rd_dm_ff    <= DB'(dm_ff);
      rd_pt_ff    <= pt_ff;
      rd_first_ff <= (dm_ff == '0);
      rd_last_ff  <= (dm_ff == dims - 1'b1);
   end

   assign ctrl.coord_valid = rd_v_ff && !rd_pre_ff;
   assign ctrl.first_dim   = rd_first_ff;
   assign ctrl.last_dim    = rd_last_ff;

   fpo_dist #(.COORD_BITS(COORD_BITS)) u_dist (
      .clock(clock), .reset(reset), .ctrl(ctrl),
      .coord_a(st_rd_ff), .coord_b(ctr_ff[rd_dm_ff]),
      .dist_valid(dist_valid), .dist_out(pt_dist)
   );

   // Track the point index alongside the two datapath stages.
   always_ff @(posedge clock) begin
      pt1_ff    <= PB'(rd_pt_ff);
      dpt_ff    <= pt1_ff;
      upd_d_ff  <= pt_dist;
      upd_pt_ff <= dpt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         load_ff <= '0; emit_ff <= '0; choice_ff <= '0; cur_ff <= '0;
         clr_ff <= '0; pre_ff <= 1'b0; pt_ff <= '0; dm_ff <= '0; done_ff <= '0;
         best_ff <= '0; bestd_ff <= '0; upd_v_ff <= 1'b0;
         o_idx_ff <= '0; o_st_ff <= '0; o_last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         load_ff <= load_in; emit_ff <= emit_in; choice_ff <= choice_in;
         cur_ff <= cur_in; clr_ff <= clr_in; pre_ff <= pre_in; pt_ff <= pt_in;
         dm_ff <= dm_in; done_ff <= done_in; best_ff <= best_in;
         bestd_ff <= bestd_in; upd_v_ff <= dist_valid;
         o_idx_ff <= o_idx_in; o_st_ff <= o_st_in; o_last_ff <= o_last_in;
      end
   end

   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {6'd0, o_idx_ff};
   assign rsp_tuser  = o_st_ff;
   assign rsp_tlast  = o_last_ff;

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_emit: assert property (@(posedge clock) disable iff (reset)
      emit_ff <= CB'(MAX_POINTS)) else $error("emitted count overflow");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> o_st_ff == ST_OK) else $error("last on error status");
   a_noacc: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> !req_tready) else $error("accept during scan");

endmodule

/* dv/tb_farthest_point_order_top.sv */
`timescale 1ns / 100ps

// Checks the farthest-first ordering block against an in-bench predictor.
// Coordinates are loaded, then request beats pull the permutation one index
// at a time. Every request beat queues the index, last flag and status the
// predictor expects, and a checker process pops and compares each result
// beat as it leaves the block.
module tb_farthest_point_order_top;
   import fpo_pkg::*;

   localparam int  NPTS_MAX    = 1024;
   localparam int  NDIM_MAX    = 16;
   localparam int  SETTLE      = 1200;     // a clear pass plus pipeline margin
   localparam int  CYCLE_LIMIT = 400000;

   typedef struct {
      logic [9:0] index;
      logic       is_last;
      status_type status;
   } order_result_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // coord[15:0]
   logic [1:0]  req_tuser;    // command[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // point_index[9:0]
   logic [1:0]  rsp_tuser;    // status[1:0]
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [10:0] csr_data;

   farthest_point_order_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Predictor state: its own copy of the point store, the per-point nearest
   // distances, the traversal counters and the three registers.
   logic signed [15:0] coord_mem [NPTS_MAX*NDIM_MAX];
   logic [37:0]        near_sq   [NPTS_MAX];
   int unsigned        loaded_coords;
   int unsigned        next_choice;
   int unsigned        emitted;
   logic [10:0]        reg_points;
   logic [4:0]         reg_dims;
   logic [9:0]         reg_start;

   order_result_t pending_indices[$];
   int  mismatches;
   int  results_seen;
   int  beats_sent;
   int  cycles;
   bit  calm;          // when set, neither side inserts gaps
   int  stall_left;
   int  tie_mode;      // coordinates drawn from a tiny set to force ties

   always #5 clock = ~clock;

   // Gap lengths: mostly none, some short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [15:0] pick_coord();
      if (tie_mode != 0) return 16'(($urandom_range(0, 2) - 1) * 256);
      return 16'($urandom);
   endfunction

   function automatic void reset_traversal();
      loaded_coords = 0;
      next_choice   = 0;
      emitted       = 0;
      for (int i = 0; i < NPTS_MAX; i++) near_sq[i] = '1;
   endfunction

   // Applies one accepted input beat to the predictor and queues the result
   // a request beat must produce.
   function automatic void track_order_beat(cmd_type cmd, logic signed [15:0] c);
      int unsigned   np, nd, cur, best;
      longint        diff;
      longint unsigned mag, sum, best_d;
      order_result_t want;
      np = (reg_points == 0) ? 1 : ((reg_points > NPTS_MAX) ? NPTS_MAX : reg_points);
      nd = (reg_dims == 0) ? 1 : ((reg_dims > NDIM_MAX) ? NDIM_MAX : reg_dims);
      want.index = '0;
      want.is_last = 1'b0;
      want.status = ST_OK;
      case (cmd)
         CMD_LOAD: begin
            if (loaded_coords < np * nd) begin
               coord_mem[loaded_coords] = c;
               loaded_coords++;
            end
         end
         CMD_CLEAR: reset_traversal();
         CMD_REQUEST: begin
            if (loaded_coords < np * nd) begin
               want.status = ST_NOT_READY;
            end else if (emitted >= np) begin
               want.status = ST_DONE;
            end else begin
               if (emitted == 0) cur = (reg_start < np) ? reg_start : 0;
               else cur = (next_choice < np) ? next_choice : 0;
               best = 0;
               best_d = 0;
               for (int unsigned j = 0; j < np; j++) begin
                  sum = 0;
                  for (int unsigned k = 0; k < nd; k++) begin
                     diff = longint'(coord_mem[j*nd+k]) - longint'(coord_mem[cur*nd+k]);
                     mag = (diff < 0) ? -diff : diff;
                     sum += mag * mag;
                  end
                  // Saturation cannot trigger at 16-bit coordinates, but the
                  // distance still has to fit the 38-bit store.
                  if (sum > 38'h3F_FFFF_FFFF) sum = 38'h3F_FFFF_FFFF;
                  if (sum < near_sq[j]) near_sq[j] = sum;
                  if (j == 0 || near_sq[j] > best_d) begin
                     best_d = near_sq[j];
                     best = j;
                  end
               end
               next_choice = best;
               emitted++;
               want.index = cur[9:0];
               want.is_last = (emitted == np);
            end
         end
         default: ;
      endcase
      if (cmd == CMD_REQUEST) pending_indices = {pending_indices, want};
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at result %0d: %s got %0d expected %0d",
         results_seen, what, got, want);
      mismatches++;
   endtask

   // Result checker: each accepted result beat against the oldest expectation.
   always @(posedge clock) begin
      order_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_indices.size() == 0) begin
            report_mismatch("unexpected beat, index", rsp_tdata[9:0], -1);
         end else begin
            want = pending_indices.pop_front();
            if (rsp_tuser !== want.status)
               report_mismatch("status", rsp_tuser, want.status);
            if (rsp_tdata[9:0] !== want.index)
               report_mismatch("point_index", rsp_tdata[9:0], want.index);
            if (rsp_tlast !== want.is_last)
               report_mismatch("last", rsp_tlast, want.is_last);
         end
         results_seen++;
      end
   end

   // Receiver side: random back-pressure on the result stream.
   always @(posedge clock) begin
      int g;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         g = pick_gap();
         rsp_tready <= (g == 0);
         stall_left <= (g > 0) ? g - 1 : 0;
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
            cycles, pending_indices.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Sends one beat. Valid stays high across back-to-back beats, so it is
   // only lowered when a gap is taken first.
   task automatic send_beat(cmd_type cmd, logic signed [15:0] c);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      track_order_beat(cmd, c);
      beats_sent++;
   endtask

   // Lets the block go quiet: all results back, then room for a clear pass.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_indices.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [10:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_POINT_COUNT: reg_points = value;
         REG_DIMS_IN_USE: reg_dims = value[4:0];
         default:         reg_start = value[9:0];
      endcase
   endtask

   task automatic set_shape(logic [10:0] pts, logic [10:0] dims, logic [10:0] start);
      settle();
      write_reg(REG_POINT_COUNT, pts);
      write_reg(REG_DIMS_IN_USE, dims);
      write_reg(REG_START_INDEX, start);
   endtask

   task automatic load_points(int n);
      repeat (n) send_beat(CMD_LOAD, pick_coord());
   endtask

   task automatic request_indices(int n);
      repeat (n) send_beat(CMD_REQUEST, 16'sd0);
   endtask

   // Reset values: a single point of one dimension. Covers a request before
   // loading, the one-point permutation, completion, a load into a full store
   // and the unused command.
   task automatic test_reset_defaults();
      request_indices(1);
      send_beat(CMD_LOAD, -16'sd32768);
      send_beat(CMD_LOAD, 16'sd32767);
      send_beat(CMD_NONE, 16'sd0);
      request_indices(2);
   endtask

   // A small set with coordinate extremes, a start index out of range, a
   // register change in the middle of a traversal and a clear that keeps the
   // store but restarts loading.
   task automatic test_small_extremes();
      set_shape(4, 2, 7);
      send_beat(CMD_CLEAR, 16'sd0);
      send_beat(CMD_LOAD, -16'sd32768);
      send_beat(CMD_LOAD, 16'sd32767);
      request_indices(1);
      send_beat(CMD_LOAD, 16'sd32767);
      send_beat(CMD_LOAD, -16'sd32768);
      send_beat(CMD_LOAD, 16'sd0);
      send_beat(CMD_LOAD, 16'sd0);
      send_beat(CMD_LOAD, 16'sd1);
      send_beat(CMD_LOAD, -16'sd1);
      request_indices(2);
      // Shrinking the set ends the traversal, growing it asks for more loads.
      set_shape(2, 2, 7);
      request_indices(1);
      set_shape(5, 2, 0);
      request_indices(1);
      set_shape(4, 2, 3);
      request_indices(3);
      send_beat(CMD_CLEAR, 16'sd0);
      load_points(8);
      request_indices(5);
   endtask

   // Register values of zero act as one.
   task automatic test_zero_registers();
      set_shape(0, 0, 0);
      send_beat(CMD_CLEAR, 16'sd0);
      load_points(1);
      request_indices(2);
   endtask

   // An oversized dimension count clamps to 16 coordinates per point; the
   // loads go back to back.
   task automatic test_clamped_dims();
      set_shape(11'd2, 11'd31, 11'd1);
      send_beat(CMD_CLEAR, 16'sd0);
      calm = 1'b1;
      load_points(2 * NDIM_MAX);
      calm = 1'b0;
      request_indices(3);
   endtask

   // Random sets, mostly well formed with random content, with some stray
   // requests and unused commands mixed into the loading.
   task automatic test_random_sets();
      int pts, dims;
      repeat (2) begin
         pts  = $urandom_range(2, 6);
         dims = $urandom_range(1, 3);
         tie_mode = ($urandom_range(0, 2) == 0);
         set_shape(pts, dims, $urandom_range(0, pts + 1));
         send_beat(CMD_CLEAR, 16'sd0);
         for (int i = 0; i < pts * dims; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_beat(($urandom_range(0, 1) != 0) ? CMD_REQUEST : CMD_NONE,
                  16'($urandom));
            send_beat(CMD_LOAD, pick_coord());
         end
         request_indices(pts + $urandom_range(0, 1));
      end
      tie_mode = 0;
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_valid = 1'b0;
      csr_index = REG_POINT_COUNT;
      csr_data = '0;
      mismatches = 0;
      results_seen = 0;
      beats_sent = 0;
      cycles = 0;
      calm = 1'b0;
      tie_mode = 0;
      reg_points = 11'd1;
      reg_dims = 5'd1;
      reg_start = 10'd0;
      reset_traversal();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_small_extremes();
      test_zero_registers();
      test_clamped_dims();
      test_random_sets();
      settle();

      $display("covered %0d input beats and %0d results over small, zero and clamped sets,",
         beats_sent, results_seen);
      $display("including ties, early and late requests and mid-traversal changes");
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
